[hdl/assert_macros.svh]
// Assertion macros for the mapper RTL.
// No dependencies; compiled out when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TJM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tjm assertion failed");
`define TJM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("tjm assertion failed");
`else
`define TJM_ASSERT(lbl, clk, rst_n, prop)
`define TJM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[hdl/tjm_pkg.sv]
// Shared constants and types for the touch joystick mapper.
// No dependencies.
package tjm_pkg;
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic CMD_TOUCH   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIUS,
    REG_DEAD_ZONE
  } cfg_addr_t;
endpackage

[hdl/tjm_in_if.sv]
// Input channel: touch or release items.
// Depends on tjm_pkg.
interface tjm_in_if import tjm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COORD_BITS-1:0] touch_x;
  logic [COORD_BITS-1:0] touch_y;

  modport source (output valid, cmd, touch_x, touch_y, input ready);
  modport sink (input valid, cmd, touch_x, touch_y, output ready);
endinterface

[hdl/tjm_out_if.sv]
// Result channel: knob position and Q2.F commands.
// Depends on tjm_pkg.
interface tjm_out_if import tjm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [COORD_BITS+1:0] knob_x;
  logic signed [COORD_BITS+1:0] knob_y;
  logic signed [FRAC_BITS+1:0]  linear_cmd;
  logic signed [FRAC_BITS+1:0]  angular_cmd;
  logic                        active;

  modport source (output valid, knob_x, knob_y, linear_cmd, angular_cmd, active,
                  input ready);
  modport sink (input valid, knob_x, knob_y, linear_cmd, angular_cmd, active,
                output ready);
endinterface

[hdl/tjm_cfg_if.sv]
// Configuration write channel: register address and data.
// Depends on tjm_pkg.
interface tjm_cfg_if import tjm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
);
  localparam int DATA_W = (COORD_BITS > FRAC_BITS + 1) ? COORD_BITS : FRAC_BITS + 1;

  logic              valid;
  logic              ready;
  cfg_addr_t         addr;
  logic [DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

[hdl/touch_joystick_mapper.sv]
// Touch joystick mapper top level: front end, queue, back end.
// Accepted items pass through the clamp divider, root and command divider pipelines;
// one item per cycle while the output is not stalled.
// An output stall freezes the back end; the queue and front register absorb three items.
// Reset clears all valid flags and loads center 2^(COORD_BITS-1), radius
// 2^(COORD_BITS-4) and dead zone 2^FRAC_BITS/10 (2048, 256, 1638 at defaults).
module touch_joystick_mapper import tjm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tjm_in_if.sink    in_ch,
  tjm_cfg_if.sink   cfg_ch,
  tjm_out_if.source out_ch
);
  localparam int ENT_W = 8 * COORD_BITS + 4;

  logic [COORD_BITS-1:0] center_x, center_y;
  logic [COORD_BITS-2:0] radius;
  logic [FRAC_BITS:0]    dead_zone;
  logic                  push_vld, push_rdy, pop_vld, pop_rdy;
  logic [ENT_W-1:0]      push_data, pop_data;

  tjm_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ENT_W      (ENT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .dead_zone (dead_zone),
    .push_vld  (push_vld),
    .push_rdy  (push_rdy),
    .push_data (push_data)
  );

  tjm_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (push_vld),
    .push_rdy  (push_rdy),
    .push_data (push_data),
    .pop_vld   (pop_vld),
    .pop_rdy   (pop_rdy),
    .pop_data  (pop_data)
  );

  tjm_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ENT_W      (ENT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .dead_zone (dead_zone),
    .pop_vld   (pop_vld),
    .pop_rdy   (pop_rdy),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );
endmodule

[hdl/tjm_front.sv]
// Front end: configuration registers, input accept, offsets and squared distance.
// Depends on tjm_pkg, tjm_in_if, tjm_cfg_if.
module tjm_front import tjm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ENT_W      = 8 * COORD_BITS_DEF + 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tjm_in_if.sink                in_ch,
  tjm_cfg_if.sink               cfg_ch,
  output logic [COORD_BITS-1:0] center_x,
  output logic [COORD_BITS-1:0] center_y,
  output logic [COORD_BITS-2:0] radius,
  output logic [FRAC_BITS:0]    dead_zone,
  output logic                  push_vld,
  input  logic                  push_rdy,
  output logic [ENT_W-1:0]      push_data
);
  localparam int C = COORD_BITS;
  localparam logic [C-1:0]         CENTER_RST = (C)'(1) << (C - 1);
  localparam logic [C-2:0]         RADIUS_RST = (C - 1)'(1) << (C - 4);
  localparam logic [FRAC_BITS:0]   DZ_RST     = (FRAC_BITS + 1)'((1 << FRAC_BITS) / 10);

  logic [C-1:0]       center_x_r, center_y_r;
  logic [C-2:0]       radius_r;
  logic [FRAC_BITS:0] dead_zone_r;

  logic               f_vld_r, f_vld_nxt;
  logic [ENT_W-1:0]   f_data_r, f_data_nxt;
  logic               accept, push;

  logic signed [C:0]  dx, dy;
  logic [C:0]         neg_x, neg_y;
  logic [C-1:0]       mag_x, mag_y;
  logic [2*C-1:0]     sq_x, sq_y;
  logic [2*C:0]       d2;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= CENTER_RST;
      center_y_r  <= CENTER_RST;
      radius_r    <= RADIUS_RST;
      dead_zone_r <= DZ_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_CENTER_X:  center_x_r  <= cfg_ch.data[C-1:0];
        REG_CENTER_Y:  center_y_r  <= cfg_ch.data[C-1:0];
        REG_RADIUS:    radius_r    <= cfg_ch.data[C-2:0];
        REG_DEAD_ZONE: dead_zone_r <= cfg_ch.data[FRAC_BITS:0];
        default: ;
      endcase
    end
  end

  assign center_x  = center_x_r;
  assign center_y  = center_y_r;
  assign radius    = radius_r;
  assign dead_zone = dead_zone_r;

  assign dx    = signed'({1'b0, in_ch.touch_x}) - signed'({1'b0, center_x_r});
  assign dy    = signed'({1'b0, in_ch.touch_y}) - signed'({1'b0, center_y_r});
  assign neg_x = -dx;
  assign neg_y = -dy;
  assign mag_x = dx[C] ? neg_x[C-1:0] : dx[C-1:0];
  assign mag_y = dy[C] ? neg_y[C-1:0] : dy[C-1:0];
  assign sq_x  = mag_x * mag_x;
  assign sq_y  = mag_y * mag_y;
  assign d2    = {1'b0, sq_x} + {1'b0, sq_y};

  assign push         = f_vld_r && push_rdy;
  assign in_ch.ready  = !f_vld_r || push_rdy;
  assign accept       = in_ch.valid && in_ch.ready;
  assign f_vld_nxt    = accept ? 1'b1 : (push ? 1'b0 : f_vld_r);
  assign f_data_nxt   = {in_ch.cmd == CMD_RELEASE, dx[C], dy[C], mag_x, mag_y,
                         sq_x, sq_y, d2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_data_r <= f_data_nxt;
    end
  end

  assign push_vld  = f_vld_r;
  assign push_data = f_data_r;
endmodule

[hdl/tjm_queue.sv]
// Short queue between front end and back end.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module tjm_queue #(
  parameter int WIDTH = 100,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_vld,
  output logic             push_rdy,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_vld,
  input  logic             pop_rdy,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_rdy = cnt_r != CNT_W'(DEPTH);
  assign pop_vld  = cnt_r != '0;
  assign push     = push_vld && push_rdy;
  assign pop      = pop_vld && pop_rdy;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `TJM_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH))
  `TJM_ASSERT(a_empty_ptrs, clk, rst_n, (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
  `TJM_ASSERT(a_cnt_inc, clk, rst_n, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
endmodule

[hdl/tjm_div2.sv]
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
// No dependencies.
module tjm_div2 #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 25,
  parameter int QUO_W = 22,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num_a,
  input  logic [NUM_W-1:0] in_num_b,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [QUO_W-1:0] out_quo_a,
  output logic [QUO_W-1:0] out_quo_b,
  output logic [TAG_W-1:0] out_tag
);
  logic             vld_r   [QUO_W];
  logic [QUO_W-1:0] lo_a_r  [QUO_W];
  logic [QUO_W-1:0] lo_b_r  [QUO_W];
  logic [TAG_W-1:0] tag_r   [QUO_W];
  logic [DEN_W-1:0] rem_a_r [QUO_W-1];
  logic [DEN_W-1:0] rem_b_r [QUO_W-1];
  logic [DEN_W-1:0] den_r   [QUO_W-1];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stg
    logic             vld_in;
    logic [DEN_W-1:0] rem_a_in, rem_b_in, den_in;
    logic [QUO_W-1:0] lo_a_in, lo_b_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   t_a, t_b, d_e;
    logic             ge_a, ge_b;

    if (k == 0) begin : g_head
      assign vld_in   = in_vld;
      assign rem_a_in = DEN_W'(in_num_a >> QUO_W);
      assign rem_b_in = DEN_W'(in_num_b >> QUO_W);
      assign lo_a_in  = in_num_a[QUO_W-1:0];
      assign lo_b_in  = in_num_b[QUO_W-1:0];
      assign den_in   = in_den;
      assign tag_in   = in_tag;
    end else begin : g_body
      assign vld_in   = vld_r[k-1];
      assign rem_a_in = rem_a_r[k-1];
      assign rem_b_in = rem_b_r[k-1];
      assign lo_a_in  = lo_a_r[k-1];
      assign lo_b_in  = lo_b_r[k-1];
      assign den_in   = den_r[k-1];
      assign tag_in   = tag_r[k-1];
    end

    assign d_e  = {1'b0, den_in};
    assign t_a  = {rem_a_in, lo_a_in[QUO_W-1]};
    assign t_b  = {rem_b_in, lo_b_in[QUO_W-1]};
    assign ge_a = t_a >= d_e;
    assign ge_b = t_b >= d_e;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lo_a_r[k] <= {lo_a_in[QUO_W-2:0], ge_a};
        lo_b_r[k] <= {lo_b_in[QUO_W-2:0], ge_b};
        tag_r[k]  <= tag_in;
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      logic [DEN_W:0] diff_a, diff_b;
      assign diff_a = t_a - d_e;
      assign diff_b = t_b - d_e;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_a_r[k] <= ge_a ? diff_a[DEN_W-1:0] : t_a[DEN_W-1:0];
          rem_b_r[k] <= ge_b ? diff_b[DEN_W-1:0] : t_b[DEN_W-1:0];
          den_r[k]   <= den_in;
        end
      end
    end
  end

  assign out_vld   = vld_r[QUO_W-1];
  assign out_quo_a = lo_a_r[QUO_W-1];
  assign out_quo_b = lo_b_r[QUO_W-1];
  assign out_tag   = tag_r[QUO_W-1];
endmodule

[hdl/tjm_sqrt2.sv]
// Two-lane pipelined integer square root, one root bit per stage.
// No dependencies.
module tjm_sqrt2 #(
  parameter int VAL_W = 22,
  parameter int TAG_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [VAL_W-1:0]   in_val_a,
  input  logic [VAL_W-1:0]   in_val_b,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [VAL_W/2-1:0] out_root_a,
  output logic [VAL_W/2-1:0] out_root_b,
  output logic [TAG_W-1:0]   out_tag
);
  localparam int RT_W = VAL_W / 2;
  localparam int RM_W = RT_W + 2;

  logic             vld_r    [RT_W];
  logic [RT_W-1:0]  root_a_r [RT_W];
  logic [RT_W-1:0]  root_b_r [RT_W];
  logic [TAG_W-1:0] tag_r    [RT_W];
  logic [RM_W-1:0]  rem_a_r  [RT_W-1];
  logic [RM_W-1:0]  rem_b_r  [RT_W-1];
  logic [VAL_W-1:0] v_a_r    [RT_W-1];
  logic [VAL_W-1:0] v_b_r    [RT_W-1];

  for (genvar k = 0; k < RT_W; k++) begin : g_stg
    logic             vld_in;
    logic [RM_W-1:0]  rem_a_in, rem_b_in;
    logic [RT_W-1:0]  root_a_in, root_b_in;
    logic [VAL_W-1:0] v_a_in, v_b_in;
    logic [TAG_W-1:0] tag_in;
    logic [RM_W-1:0]  t_a, t_b, trial_a, trial_b;
    logic             ge_a, ge_b;

    if (k == 0) begin : g_head
      assign vld_in    = in_vld;
      assign rem_a_in  = '0;
      assign rem_b_in  = '0;
      assign root_a_in = '0;
      assign root_b_in = '0;
      assign v_a_in    = in_val_a;
      assign v_b_in    = in_val_b;
      assign tag_in    = in_tag;
    end else begin : g_body
      assign vld_in    = vld_r[k-1];
      assign rem_a_in  = rem_a_r[k-1];
      assign rem_b_in  = rem_b_r[k-1];
      assign root_a_in = root_a_r[k-1];
      assign root_b_in = root_b_r[k-1];
      assign v_a_in    = v_a_r[k-1];
      assign v_b_in    = v_b_r[k-1];
      assign tag_in    = tag_r[k-1];
    end

    assign t_a     = {rem_a_in[RM_W-3:0], v_a_in[VAL_W-1 -: 2]};
    assign t_b     = {rem_b_in[RM_W-3:0], v_b_in[VAL_W-1 -: 2]};
    assign trial_a = {root_a_in, 2'b01};
    assign trial_b = {root_b_in, 2'b01};
    assign ge_a    = t_a >= trial_a;
    assign ge_b    = t_b >= trial_b;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_a_r[k] <= {root_a_in[RT_W-2:0], ge_a};
        root_b_r[k] <= {root_b_in[RT_W-2:0], ge_b};
        tag_r[k]    <= tag_in;
      end
    end

    if (k < RT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_a_r[k] <= ge_a ? t_a - trial_a : t_a;
          rem_b_r[k] <= ge_b ? t_b - trial_b : t_b;
          v_a_r[k]   <= v_a_in << 2;
          v_b_r[k]   <= v_b_in << 2;
        end
      end
    end
  end

  assign out_vld    = vld_r[RT_W-1];
  assign out_root_a = root_a_r[RT_W-1];
  assign out_root_b = root_b_r[RT_W-1];
  assign out_tag    = tag_r[RT_W-1];
endmodule

[hdl/tjm_back.sv]
// Back end: radial clamp, command division, dead zone and the output register.
// Depends on tjm_pkg, tjm_out_if, tjm_div2, tjm_sqrt2.
module tjm_back import tjm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ENT_W      = 8 * COORD_BITS_DEF + 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-2:0] radius,
  input  logic [FRAC_BITS:0]    dead_zone,
  input  logic                  pop_vld,
  output logic                  pop_rdy,
  input  logic [ENT_W-1:0]      pop_data,
  tjm_out_if.source             out_ch
);
  localparam int C      = COORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int SQ_W   = 2 * C;
  localparam int D2_W   = 2 * C + 1;
  localparam int R_W    = C - 1;
  localparam int R2_W   = 2 * C - 2;
  localparam int NUM_W  = SQ_W + R2_W;
  localparam int T1_W   = 2 * C + 4;
  localparam int T2_W   = 2 * C + 3;
  localparam int Q_W    = F + 1;
  localparam logic [F:0] FULL = (F + 1)'(1) << F;

  logic            en;
  logic [R_W-1:0]  r_eff;
  logic [R2_W-1:0] r2_r;

  logic            q_rel, q_sx, q_sy;
  logic [C-1:0]    q_magx, q_magy;
  logic [SQ_W-1:0] q_sqx, q_sqy;
  logic [D2_W-1:0] q_d2;

  logic             m_vld_r;
  logic [NUM_W-1:0] m_numx_r, m_numy_r;
  logic [D2_W-1:0]  m_d2_r;
  logic [T1_W-1:0]  m_tag_r;

  logic             d1_vld;
  logic [R2_W-1:0]  d1_qx, d1_qy;
  logic [T1_W-1:0]  d1_tag;

  logic             s_vld;
  logic [R_W-1:0]   s_rx, s_ry;
  logic [T1_W-1:0]  s_tag;
  logic             t_rel, t_sx, t_sy, t_clamp;
  logic [C-1:0]     t_magx, t_magy, offx, offy;

  logic             c_vld;
  logic [Q_W-1:0]   c_qx, c_qy;
  logic [T2_W-1:0]  c_tag;
  logic             c_rel, c_sx, c_sy;
  logic [C-1:0]     c_offx, c_offy;

  logic [F:0]       ang_mag, lin_mag;
  logic [F+1:0]     ang_e, lin_e, ang_val, lin_val;
  logic [C+1:0]     offx_e, offy_e, kx_val, ky_val;

  logic             out_vld_r;
  logic [C+1:0]     knob_x_r, knob_y_r, knob_x_nxt, knob_y_nxt;
  logic [F+1:0]     lin_r, ang_r, lin_nxt, ang_nxt;
  logic             active_r, active_nxt;

  assign en      = !out_vld_r || out_ch.ready;
  assign pop_rdy = en;
  assign r_eff   = (radius == '0) ? R_W'(1) : radius;

  always_ff @(posedge clk) begin
    r2_r <= r_eff * r_eff;
  end

  assign {q_rel, q_sx, q_sy, q_magx, q_magy, q_sqx, q_sqy, q_d2} = pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= pop_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_numx_r <= q_sqx * r2_r;
      m_numy_r <= q_sqy * r2_r;
      m_d2_r   <= q_d2;
      m_tag_r  <= {q_rel, q_sx, q_sy, q_magx, q_magy, q_d2 > D2_W'(r2_r)};
    end
  end

  tjm_div2 #(
    .NUM_W (NUM_W),
    .DEN_W (D2_W),
    .QUO_W (R2_W),
    .TAG_W (T1_W)
  ) u_div_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (m_vld_r),
    .in_num_a  (m_numx_r),
    .in_num_b  (m_numy_r),
    .in_den    (m_d2_r),
    .in_tag    (m_tag_r),
    .out_vld   (d1_vld),
    .out_quo_a (d1_qx),
    .out_quo_b (d1_qy),
    .out_tag   (d1_tag)
  );

  tjm_sqrt2 #(
    .VAL_W (R2_W),
    .TAG_W (T1_W)
  ) u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (d1_vld),
    .in_val_a   (d1_qx),
    .in_val_b   (d1_qy),
    .in_tag     (d1_tag),
    .out_vld    (s_vld),
    .out_root_a (s_rx),
    .out_root_b (s_ry),
    .out_tag    (s_tag)
  );

  assign {t_rel, t_sx, t_sy, t_magx, t_magy, t_clamp} = s_tag;
  assign offx = t_clamp ? {1'b0, s_rx} : t_magx;
  assign offy = t_clamp ? {1'b0, s_ry} : t_magy;

  tjm_div2 #(
    .NUM_W (C + F),
    .DEN_W (R_W),
    .QUO_W (Q_W),
    .TAG_W (T2_W)
  ) u_div_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (s_vld),
    .in_num_a  ({offx, {F{1'b0}}}),
    .in_num_b  ({offy, {F{1'b0}}}),
    .in_den    (r_eff),
    .in_tag    ({t_rel, t_sx, t_sy, offx, offy}),
    .out_vld   (c_vld),
    .out_quo_a (c_qx),
    .out_quo_b (c_qy),
    .out_tag   (c_tag)
  );

  assign {c_rel, c_sx, c_sy, c_offx, c_offy} = c_tag;

  always_comb begin
    ang_mag = (c_qx < dead_zone) ? '0 : ((c_qx > FULL) ? FULL : c_qx);
    lin_mag = (c_qy < dead_zone) ? '0 : ((c_qy > FULL) ? FULL : c_qy);
    ang_e   = {1'b0, ang_mag};
    lin_e   = {1'b0, lin_mag};
    ang_val = c_sx ? -ang_e : ang_e;
    lin_val = c_sy ? lin_e : -lin_e;
    offx_e  = {2'b00, c_offx};
    offy_e  = {2'b00, c_offy};
    kx_val  = {2'b00, center_x} + (c_sx ? -offx_e : offx_e);
    ky_val  = {2'b00, center_y} + (c_sy ? -offy_e : offy_e);
    if (c_rel) begin
      knob_x_nxt = {2'b00, center_x};
      knob_y_nxt = {2'b00, center_y};
      lin_nxt    = '0;
      ang_nxt    = '0;
      active_nxt = 1'b0;
    end else begin
      knob_x_nxt = kx_val;
      knob_y_nxt = ky_val;
      lin_nxt    = lin_val;
      ang_nxt    = ang_val;
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      knob_x_r <= knob_x_nxt;
      knob_y_r <= knob_y_nxt;
      lin_r    <= lin_nxt;
      ang_r    <= ang_nxt;
      active_r <= active_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.knob_x      = signed'(knob_x_r);
  assign out_ch.knob_y      = signed'(knob_y_r);
  assign out_ch.linear_cmd  = signed'(lin_r);
  assign out_ch.angular_cmd = signed'(ang_r);
  assign out_ch.active      = active_r;
endmodule

[tb/tjm_checker.sv]
// Checker for the touch joystick mapper: predicts each result from accepted inputs.
// Depends on tjm_pkg and the tjm_in_if, tjm_out_if and tjm_cfg_if interfaces.
`timescale 1ns / 1ps
module tjm_checker import tjm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tjm_in_if    in_ch,
  tjm_cfg_if   cfg_ch,
  tjm_out_if   out_ch,
  output int   fail_count,
  output int   pending_count,
  output int   result_count
);
  typedef struct packed {
    logic signed [13:0] knob_x;
    logic signed [13:0] knob_y;
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               active;
  } stick_t;

  stick_t expected_q[$];
  logic [11:0] cen_x, cen_y;
  logic [10:0] rad;
  logic [14:0] dzone;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint shrink_offset(longint d, longint unsigned d2,
                                           longint unsigned r2);
    longint unsigned mag, s;
    mag = (d < 0) ? -d : d;
    s = int_sqrt((mag * mag * r2) / d2);
    return (d < 0) ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint deflection(longint off, longint r);
    longint full, v, mag;
    full = 64'sd1 << 14;
    v = (off * full) / r;
    mag = (v < 0) ? -v : v;
    if (mag < longint'(dzone)) v = 0;
    if (v > full) v = full;
    if (v < -full) v = -full;
    return v;
  endfunction

  function automatic stick_t predict_stick(logic cmd, logic [11:0] tx, logic [11:0] ty);
    stick_t res;
    longint r, dx, dy;
    longint unsigned d2, r2;
    res = '0;
    if (cmd == CMD_RELEASE) begin
      res.knob_x = 14'(cen_x);
      res.knob_y = 14'(cen_y);
      return res;
    end
    r = (rad == 0) ? 1 : longint'(rad);
    dx = longint'(tx) - longint'(cen_x);
    dy = longint'(ty) - longint'(cen_y);
    d2 = dx * dx + dy * dy;
    r2 = r * r;
    if (d2 > r2) begin
      dx = shrink_offset(dx, d2, r2);
      dy = shrink_offset(dy, d2, r2);
    end
    res.knob_x = 14'(longint'(cen_x) + dx);
    res.knob_y = 14'(longint'(cen_y) + dy);
    res.linear_cmd = 16'(deflection(-dy, r));
    res.angular_cmd = 16'(deflection(dx, r));
    res.active = 1'b1;
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    stick_t want;
    if (!rst_n) begin
      cen_x <= 12'd2048;
      cen_y <= 12'd2048;
      rad <= 11'd256;
      dzone <= 15'd1638;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_CENTER_X:  cen_x <= cfg_ch.data[11:0];
          REG_CENTER_Y:  cen_y <= cfg_ch.data[11:0];
          REG_RADIUS:    rad <= cfg_ch.data[10:0];
          REG_DEAD_ZONE: dzone <= cfg_ch.data[14:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(predict_stick(in_ch.cmd, in_ch.touch_x, in_ch.touch_y));
      if (out_ch.valid && out_ch.ready) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          report("unexpected transfer", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.knob_x !== want.knob_x) report("knob_x", out_ch.knob_x, want.knob_x);
          if (out_ch.knob_y !== want.knob_y) report("knob_y", out_ch.knob_y, want.knob_y);
          if (out_ch.linear_cmd !== want.linear_cmd)
            report("linear_cmd", out_ch.linear_cmd, want.linear_cmd);
          if (out_ch.angular_cmd !== want.angular_cmd)
            report("angular_cmd", out_ch.angular_cmd, want.angular_cmd);
          if (out_ch.active !== want.active) report("active", out_ch.active, want.active);
        end
      end
      pending_count <= expected_q.size();
    end
  end
endmodule

[tb/testbench.sv]
// Top of the touch joystick mapper testbench: clock, reset, stimulus and verdict.
// Depends on tjm_pkg, the channel interfaces, touch_joystick_mapper and tjm_checker.
`timescale 1ns / 1ps
module testbench;
  import tjm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int fail_count, pending_count, result_count;
  int touch_count, release_count;
  bit gen_done = 0;

  tjm_in_if  in_ch ();
  tjm_cfg_if cfg_ch ();
  tjm_out_if out_ch ();

  touch_joystick_mapper u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_ch(cfg_ch), .out_ch(out_ch)
  );

  tjm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_ch(cfg_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      out_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
  end

  task automatic write_reg(cfg_addr_t idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= value[14:0];
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(logic cmd, logic [11:0] tx, logic [11:0] ty, bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.touch_x <= tx;
    in_ch.touch_y <= ty;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (cmd == CMD_RELEASE) release_count++; else touch_count++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic random_touches(int n, int rmax);
    logic [11:0] tx, ty;
    int mode;
    bit idle;
    idle = ($urandom_range(0, 2) != 0);
    repeat (n) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        tx = 12'($urandom_range(0, 2 * rmax) + 2048 - rmax);
        ty = 12'($urandom_range(0, 2 * rmax) + 2048 - rmax);
      end else begin
        tx = 12'($urandom);
        ty = 12'($urandom);
      end
      send_item(($urandom_range(0, 7) == 0) ? CMD_RELEASE : CMD_TOUCH, tx, ty, idle);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TOUCH;
    in_ch.touch_x = '0;
    in_ch.touch_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_CENTER_X;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(CMD_TOUCH, 12'd2048, 12'd2048, 0);
    send_item(CMD_TOUCH, 12'd0, 12'd0, 0);
    send_item(CMD_TOUCH, 12'd4095, 12'd4095, 0);
    send_item(CMD_TOUCH, 12'd0, 12'd4095, 0);
    send_item(CMD_TOUCH, 12'd4095, 12'd0, 0);
    send_item(CMD_TOUCH, 12'd2048, 12'd2304, 0);
    send_item(CMD_TOUCH, 12'd2304, 12'd2048, 0);
    send_item(CMD_TOUCH, 12'd2074, 12'd2022, 0);
    send_item(CMD_TOUCH, 12'd2073, 12'd2023, 0);
    send_item(CMD_RELEASE, 12'd4095, 12'd4095, 0);
    send_item(CMD_RELEASE, 12'd0, 12'd0, 0);
    drain();

    write_reg(REG_RADIUS, 0);
    write_reg(REG_DEAD_ZONE, 0);
    write_reg(REG_CENTER_X, 0);
    write_reg(REG_CENTER_Y, 4095);
    send_item(CMD_TOUCH, 12'd0, 12'd4095, 0);
    send_item(CMD_TOUCH, 12'd1, 12'd4094, 0);
    send_item(CMD_TOUCH, 12'd4095, 12'd0, 0);
    send_item(CMD_RELEASE, 12'd5, 12'd5, 0);
    drain();
    write_reg(REG_RADIUS, 2047);
    write_reg(REG_DEAD_ZONE, 32767);
    write_reg(REG_CENTER_X, 4095);
    write_reg(REG_CENTER_Y, 0);
    send_item(CMD_TOUCH, 12'd0, 12'd4095, 0);
    send_item(CMD_TOUCH, 12'd4000, 12'd100, 0);
    drain();

    write_reg(REG_CENTER_X, 2048);
    write_reg(REG_CENTER_Y, 2048);
    write_reg(REG_RADIUS, 256);
    write_reg(REG_DEAD_ZONE, 1638);
    random_touches(150, 400);
    drain();
    write_reg(REG_DEAD_ZONE, 16384);
    write_reg(REG_RADIUS, 2047);
    random_touches(100, 2047);
    drain();
    write_reg(REG_DEAD_ZONE, 16385);
    write_reg(REG_RADIUS, 1);
    random_touches(50, 3);
    drain();
    repeat (4) begin
      write_reg(REG_CENTER_X, $urandom_range(0, 4095));
      write_reg(REG_CENTER_Y, $urandom_range(0, 4095));
      write_reg(REG_RADIUS, $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
                                                    : $urandom_range(1, 64));
      write_reg(REG_DEAD_ZONE, $urandom_range(0, 17000));
      random_touches(75, 100);
      drain();
    end
    gen_done = 1;
  end

  initial begin
    wait (gen_done);
    $display("covered %0d touches and %0d releases, %0d results checked",
             touch_count, release_count, result_count);
    $display("config covered all four registers, radius 0 to 2047, dead zone 0 to max");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending_count);
    $display("status: fail");
    $finish;
  end
endmodule

[files.f]
+incdir+hdl
hdl/tjm_pkg.sv
hdl/tjm_in_if.sv
hdl/tjm_out_if.sv
hdl/tjm_cfg_if.sv
hdl/tjm_front.sv
hdl/tjm_queue.sv
hdl/tjm_div2.sv
hdl/tjm_sqrt2.sv
hdl/tjm_back.sv
hdl/touch_joystick_mapper.sv
tb/tjm_checker.sv
tb/testbench.sv
